[sv/fwu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwu_pkg
// Shared types, constants and table builders for the fisheye forward warp.
// ----------------------------------------------------------------------------
package fwu_pkg;

	localparam int MAX_DIM     = 4096;
	localparam int SQRT_DEPTH  = 1024;
	localparam int EXP_DEPTH   = 1024;
	localparam int SQRT_AW     = $clog2(SQRT_DEPTH);
	localparam int EXP_AW      = $clog2(EXP_DEPTH);
	localparam int DIM_W       = 13;
	localparam int DIV_STEPS   = 17;
	localparam int LAT         = DIV_STEPS + 15;

	typedef enum logic [2:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_RADIUS_SCALE = 3'd2,
		REG_CENTRE_X     = 3'd3,
		REG_CENTRE_Y     = 3'd4,
		REG_CROP_ENABLE  = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		POL_OVERWRITE = 2'd0,
		POL_IF_BLACK  = 2'd1,
		POL_NONE      = 2'd2
	} policy_t;

	typedef struct packed {
		logic [23:0] pixel;
		logic        eof;
		policy_t     policy;
	} side_t;

	typedef logic [16:0] sqrt_rom_t [SQRT_DEPTH];
	typedef logic [16:0] exp_rom_t  [EXP_DEPTH];

	// one restoring step of c * 2^17 / dim: returns {quotient bit, remainder}
	function automatic logic [DIM_W:0] div_step(logic [DIM_W-1:0] r, logic [DIM_W-1:0] d);
		logic [DIM_W:0] r2;
		r2 = {r, 1'b0};
		if (r2 >= {1'b0, d})
			div_step = {1'b1, DIM_W'(r2 - {1'b0, d})};
		else
			div_step = {1'b0, r2[DIM_W-1:0]};
	endfunction

	function automatic logic [63:0] isqrt64(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		logic [63:0] rem;
		res  = '0;
		bitv = 64'd1 << 62;
		rem  = v;
		for (int n = 0; n < 32; n++) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		isqrt64 = res;
	endfunction

	function automatic sqrt_rom_t build_sqrt_rom();
		sqrt_rom_t t;
		logic [63:0] a;
		for (int i = 0; i < SQRT_DEPTH; i++) begin
			a = (64'(i) << 32) / 64'(SQRT_DEPTH - 1);
			t[i] = 17'(isqrt64(a));
		end
		build_sqrt_rom = t;
	endfunction

	function automatic exp_rom_t build_exp_rom();
		exp_rom_t t;
		logic [63:0] g;
		logic [63:0] term;
		logic [63:0] e;
		longint sum;
		for (int i = 0; i < EXP_DEPTH; i++) begin
			g    = (64'(i) << 32) / 64'(EXP_DEPTH - 1);
			term = 64'd1 << 30;
			sum  = 64'sd1 <<< 30;
			for (int n = 1; n <= 12; n++) begin
				term = ((term * g) >> 32) / 64'(n);
				if (n % 2 == 1)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			e = (sum < 0) ? 64'd0 : 64'(sum);
			for (int n = 0; n < 3; n++)
				e = (e * e) >> 30;
			t[i] = 17'(e >> 14);
		end
		build_exp_rom = t;
	endfunction

endpackage
`default_nettype wire

[sv/fisheye_forward_warp_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fisheye_forward_warp_unit
// Maps each source pixel to its fisheye destination and reports crop boxes.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one source pixel per item: tdata holds column, row and colour,
//   tlast marks the last pixel of a frame. m_* returns one item per source
//   pixel: destination, colour, write policy and, with tlast set on the frame
//   end, the crop rectangle. Registers are written through cfg_* while the
//   stream is idle; derived settings are computed from them and registered.
//   The pipeline has 17 one-bit divider stages for the coordinate
//   normalize, then 15 stages of squaring, table reads and multiplies.
//   Throughput is one item per cycle; the whole pipeline advances whenever
//   the output register is empty or taken, so a stalled receiver holds every
//   stage in place and s_tready drops only while the output item waits.
//   Reset clears all valid bits, loads the register defaults and reloads the
//   bounding box; the lookup tables are constants and need no fill.
// ----------------------------------------------------------------------------
module fisheye_forward_warp_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [15:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// src_col[11:0], src_row[23:12], src_pixel[47:24]
	input  wire logic [47:0]  s_tdata,
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// dest_col[11:0], dest_row[23:12], dest_pixel[47:24], write_policy[49:48],
	// crop_left[61:50], crop_top[73:62], crop_width[86:74], crop_height[99:87]
	output logic [103:0]      m_tdata,
	output logic              m_tlast
);
	import fwu_pkg::*;

	localparam sqrt_rom_t SqrtRom = build_sqrt_rom();
	localparam exp_rom_t  ExpRom  = build_exp_rom();

	// configuration
	logic [12:0] fw_q, fh_q, w_q, h_q;
	logic [15:0] rs_q, cx_q, cy_q;
	logic        ce_q;
	logic [19:0] k_q;
	logic [31:0] rs_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 13'd640;
			fh_q <= 13'd480;
			rs_q <= 16'd22938;
			cx_q <= '0;
			cy_q <= '0;
			ce_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  fw_q <= cfg_data[12:0];
				REG_FRAME_HEIGHT: fh_q <= cfg_data[12:0];
				REG_RADIUS_SCALE: rs_q <= cfg_data;
				REG_CENTRE_X:     cx_q <= cfg_data;
				REG_CENTRE_Y:     cy_q <= cfg_data;
				REG_CROP_ENABLE:  ce_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	function automatic logic [12:0] eff_dim(logic [12:0] r);
		if (r == '0)
			eff_dim = 13'd1;
		else if (r > 13'(MAX_DIM))
			eff_dim = 13'(MAX_DIM);
		else
			eff_dim = r;
	endfunction

	assign rs_sq = 32'(rs_q) * 32'(rs_q);

	always_ff @(posedge clk) begin
		w_q <= eff_dim(fw_q);
		h_q <= eff_dim(fh_q);
		k_q <= rs_sq[31:12];
	end

	// handshake
	logic [LAT:1] vld_q;
	logic         en, in_fire;
	side_t        side_q [1:LAT];
	side_t        side_in;
	logic [11:0]  in_col, in_row;
	logic [12:0]  half;

	assign en       = !vld_q[LAT] || m_tready;
	assign s_tready = en;
	assign in_fire  = s_tvalid && en;
	assign in_col   = s_tdata[11:0];
	assign in_row   = s_tdata[23:12];
	assign half     = w_q >> 1;

	always_comb begin
		side_in.pixel = s_tdata[47:24];
		side_in.eof   = s_tlast;
		if ({1'b0, in_col} < half)
			side_in.policy = POL_OVERWRITE;
		else if ({1'b0, in_col} > half)
			side_in.policy = POL_IF_BLACK;
		else
			side_in.policy = POL_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-1:1], in_fire};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[1] <= side_in;
			for (int k = 2; k <= LAT; k++)
				side_q[k] <= side_q[k-1];
		end
	end

	// normalize divider: one quotient bit per stage
	logic [12:0] dvx_r [1:DIV_STEPS];
	logic [12:0] dvy_r [1:DIV_STEPS];
	logic [16:0] dvx_q [1:DIV_STEPS];
	logic [16:0] dvy_q [1:DIV_STEPS];
	logic        dvx_sat [1:DIV_STEPS];
	logic        dvy_sat [1:DIV_STEPS];
	logic [13:0] stx [1:DIV_STEPS];
	logic [13:0] sty [1:DIV_STEPS];

	always_comb begin
		stx[1] = div_step({1'b0, in_col}, w_q);
		sty[1] = div_step({1'b0, in_row}, h_q);
		for (int k = 2; k <= DIV_STEPS; k++) begin
			stx[k] = div_step(dvx_r[k-1], w_q);
			sty[k] = div_step(dvy_r[k-1], h_q);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvx_r[1]   <= stx[1][12:0];
			dvy_r[1]   <= sty[1][12:0];
			dvx_q[1]   <= {16'd0, stx[1][13]};
			dvy_q[1]   <= {16'd0, sty[1][13]};
			dvx_sat[1] <= {1'b0, in_col} >= w_q;
			dvy_sat[1] <= {1'b0, in_row} >= h_q;
			for (int k = 2; k <= DIV_STEPS; k++) begin
				dvx_r[k]   <= stx[k][12:0];
				dvy_r[k]   <= sty[k][12:0];
				dvx_q[k]   <= {dvx_q[k-1][15:0], stx[k][13]};
				dvy_q[k]   <= {dvy_q[k-1][15:0], sty[k][13]};
				dvx_sat[k] <= dvx_sat[k-1];
				dvy_sat[k] <= dvy_sat[k-1];
			end
		end
	end

	// stage 18: sign and magnitude of the normalized coordinate
	logic [16:0] qx, qy;
	logic        nxg_s18, nyg_s18;
	logic [16:0] nxm_s18, nym_s18;

	assign qx = dvx_q[DIV_STEPS];
	assign qy = dvy_q[DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			nxg_s18 <= !dvx_sat[DIV_STEPS] && !qx[16];
			nyg_s18 <= !dvy_sat[DIV_STEPS] && !qy[16];
			if (dvx_sat[DIV_STEPS])
				nxm_s18 <= 17'd65536;
			else if (qx[16])
				nxm_s18 <= {1'b0, qx[15:0]};
			else
				nxm_s18 <= 17'd65536 - qx;
			if (dvy_sat[DIV_STEPS])
				nym_s18 <= 17'd65536;
			else if (qy[16])
				nym_s18 <= {1'b0, qy[15:0]};
			else
				nym_s18 <= 17'd65536 - qy;
		end
	end

	// stage 19: squares
	logic [33:0] sqx_w, sqy_w;
	logic [15:0] sqx_s19, sqy_s19;
	logic        nxg_s19, nyg_s19;
	logic [16:0] nxm_s19, nym_s19;

	assign sqx_w = 34'(nxm_s18) * 34'(nxm_s18);
	assign sqy_w = 34'(nym_s18) * 34'(nym_s18);

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s19 <= sqx_w[32:17];
			sqy_s19 <= sqy_w[32:17];
			nxg_s19 <= nxg_s18;
			nyg_s19 <= nyg_s18;
			nxm_s19 <= nxm_s18;
			nym_s19 <= nym_s18;
		end
	end

	// stage 20: sqrt table index; dx takes sqrt of the row term, dy of the column
	logic [16:0]           sx_w, sy_w;
	logic [16+SQRT_AW:0]   ixp_w, iyp_w;
	logic [SQRT_AW-1:0]    idx_dx_s20, idx_dy_s20;
	logic                  nxg_s20, nyg_s20;
	logic [16:0]           nxm_s20, nym_s20;

	assign sx_w  = 17'd65536 - 17'(sqx_s19);
	assign sy_w  = 17'd65536 - 17'(sqy_s19);
	assign ixp_w = (17+SQRT_AW)'(sy_w) * (17+SQRT_AW)'(SQRT_DEPTH - 1);
	assign iyp_w = (17+SQRT_AW)'(sx_w) * (17+SQRT_AW)'(SQRT_DEPTH - 1);

	always_ff @(posedge clk) begin
		if (en) begin
			idx_dx_s20 <= ixp_w[16 +: SQRT_AW];
			idx_dy_s20 <= iyp_w[16 +: SQRT_AW];
			nxg_s20    <= nxg_s19;
			nyg_s20    <= nyg_s19;
			nxm_s20    <= nxm_s19;
			nym_s20    <= nym_s19;
		end
	end

	// stage 21: sqrt table read
	logic [16:0] sqd_x_s21, sqd_y_s21;
	logic        nxg_s21, nyg_s21;
	logic [16:0] nxm_s21, nym_s21;

	always_ff @(posedge clk) begin
		if (en) begin
			sqd_x_s21 <= SqrtRom[idx_dx_s20];
			sqd_y_s21 <= SqrtRom[idx_dy_s20];
			nxg_s21   <= nxg_s20;
			nyg_s21   <= nyg_s20;
			nxm_s21   <= nxm_s20;
			nym_s21   <= nym_s20;
		end
	end

	// stage 22: squeeze multiply on magnitudes
	logic [33:0] px_w, py_w;
	logic [16:0] pxm_s22, pym_s22;
	logic        nxg_s22, nyg_s22;

	assign px_w = 34'(nxm_s21) * 34'(sqd_x_s21);
	assign py_w = 34'(nym_s21) * 34'(sqd_y_s21);

	always_ff @(posedge clk) begin
		if (en) begin
			pxm_s22 <= px_w[32:16];
			pym_s22 <= py_w[32:16];
			nxg_s22 <= nxg_s21;
			nyg_s22 <= nyg_s21;
		end
	end

	// stage 23: offset from the centre, magnitude
	logic signed [18:0] dxs_w, dys_w, cx4_w, cy4_w, ofx_w, ofy_w;
	logic [17:0] ex_s23, ey_s23;
	logic [16:0] dxm_s23, dym_s23;
	logic        dxg_s23, dyg_s23;

	assign dxs_w = nxg_s22 ? -$signed({2'b00, pxm_s22}) : $signed({2'b00, pxm_s22});
	assign dys_w = nyg_s22 ? -$signed({2'b00, pym_s22}) : $signed({2'b00, pym_s22});
	assign cx4_w = $signed({cx_q[15], cx_q, 2'b00});
	assign cy4_w = $signed({cy_q[15], cy_q, 2'b00});
	assign ofx_w = dxs_w - cx4_w;
	assign ofy_w = dys_w - cy4_w;

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s23  <= ofx_w[18] ? 18'(-ofx_w) : ofx_w[17:0];
			ey_s23  <= ofy_w[18] ? 18'(-ofy_w) : ofy_w[17:0];
			dxm_s23 <= pxm_s22;
			dym_s23 <= pym_s22;
			dxg_s23 <= nxg_s22;
			dyg_s23 <= nyg_s22;
		end
	end

	// stage 24: squared offsets
	logic [35:0] exq_s24, eyq_s24;
	logic [16:0] dxm_s24, dym_s24;
	logic        dxg_s24, dyg_s24;

	always_ff @(posedge clk) begin
		if (en) begin
			exq_s24 <= 36'(ex_s23) * 36'(ex_s23);
			eyq_s24 <= 36'(ey_s23) * 36'(ey_s23);
			dxm_s24 <= dxm_s23;
			dym_s24 <= dym_s23;
			dxg_s24 <= dxg_s23;
			dyg_s24 <= dyg_s23;
		end
	end

	// stage 25: radius squared
	logic [36:0] d2sum_w;
	logic [20:0] d2_s25;
	logic [16:0] dxm_s25, dym_s25;
	logic        dxg_s25, dyg_s25;

	assign d2sum_w = 37'(exq_s24) + 37'(eyq_s24);

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s25  <= d2sum_w[36:16];
			dxm_s25 <= dxm_s24;
			dym_s25 <= dym_s24;
			dxg_s25 <= dxg_s24;
			dyg_s25 <= dyg_s24;
		end
	end

	// stage 26: exponent argument
	logic [40:0] up_w;
	logic [22:0] u_s26;
	logic [16:0] dxm_s26, dym_s26;
	logic        dxg_s26, dyg_s26;

	assign up_w = 41'(k_q) * 41'(d2_s25);

	always_ff @(posedge clk) begin
		if (en) begin
			u_s26   <= up_w[40:18];
			dxm_s26 <= dxm_s25;
			dym_s26 <= dym_s25;
			dxg_s26 <= dxg_s25;
			dyg_s26 <= dyg_s25;
		end
	end

	// stage 27: saturate at 8.0 and form the exp table index
	logic [19:0]          us_w;
	logic [19+EXP_AW:0]   eip_w;
	logic [EXP_AW-1:0]    eidx_s27;
	logic [16:0]          dxm_s27, dym_s27;
	logic                 dxg_s27, dyg_s27;

	assign us_w  = (u_s26 > 23'd524288) ? 20'd524288 : u_s26[19:0];
	assign eip_w = (20+EXP_AW)'(us_w) * (20+EXP_AW)'(EXP_DEPTH - 1);

	always_ff @(posedge clk) begin
		if (en) begin
			eidx_s27 <= eip_w[19 +: EXP_AW];
			dxm_s27  <= dxm_s26;
			dym_s27  <= dym_s26;
			dxg_s27  <= dxg_s26;
			dyg_s27  <= dyg_s26;
		end
	end

	// stage 28: exp table read
	logic [16:0] ef_s28;
	logic [16:0] dxm_s28, dym_s28;
	logic        dxg_s28, dyg_s28;

	always_ff @(posedge clk) begin
		if (en) begin
			ef_s28  <= ExpRom[eidx_s27];
			dxm_s28 <= dxm_s27;
			dym_s28 <= dym_s27;
			dxg_s28 <= dxg_s27;
			dyg_s28 <= dyg_s27;
		end
	end

	// stage 29: radial scale on magnitudes
	logic [33:0] sx2_w, sy2_w;
	logic [16:0] qxm_s29, qym_s29;
	logic        dxg_s29, dyg_s29;

	assign sx2_w = 34'(dxm_s28) * 34'(ef_s28);
	assign sy2_w = 34'(dym_s28) * 34'(ef_s28);

	always_ff @(posedge clk) begin
		if (en) begin
			qxm_s29 <= sx2_w[32:16];
			qym_s29 <= sy2_w[32:16];
			dxg_s29 <= dxg_s28;
			dyg_s29 <= dyg_s28;
		end
	end

	// stage 30: restore sign, shift into [0, 2]
	logic [17:0] vx_s30, vy_s30;

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s30 <= dxg_s29 ? 18'd65536 - 18'(qxm_s29) : 18'd65536 + 18'(qxm_s29);
			vy_s30 <= dyg_s29 ? 18'd65536 - 18'(qym_s29) : 18'd65536 + 18'(qym_s29);
		end
	end

	// stage 31: back to pixels, clamp into the frame
	logic [30:0] mx_w, my_w;
	logic [13:0] rx_w, ry_w;
	logic [11:0] dc_s31, dr_s31;

	assign mx_w = 31'(vx_s30) * 31'(w_q);
	assign my_w = 31'(vy_s30) * 31'(h_q);
	assign rx_w = mx_w[30:17];
	assign ry_w = my_w[30:17];

	always_ff @(posedge clk) begin
		if (en) begin
			dc_s31 <= (rx_w >= 14'(w_q)) ? 12'(w_q - 13'd1) : rx_w[11:0];
			dr_s31 <= (ry_w >= 14'(h_q)) ? 12'(h_q - 13'd1) : ry_w[11:0];
		end
	end

	// stage 32: bounding box and output register
	logic [12:0] mnc_q, mnr_q, mxc_q, mxr_q;
	logic [12:0] mnc_n, mnr_n, mxc_n, mxr_n;
	logic [11:0] dc_s32, dr_s32, cl_s32, ct_s32;
	logic [12:0] cw_s32, ch_s32;
	side_t       sd31;

	assign sd31  = side_q[LAT-1];
	assign mnc_n = ({1'b0, dc_s31} < mnc_q) ? {1'b0, dc_s31} : mnc_q;
	assign mnr_n = ({1'b0, dr_s31} < mnr_q) ? {1'b0, dr_s31} : mnr_q;
	assign mxc_n = ({1'b0, dc_s31} > mxc_q) ? {1'b0, dc_s31} : mxc_q;
	assign mxr_n = ({1'b0, dr_s31} > mxr_q) ? {1'b0, dr_s31} : mxr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mnc_q <= '1;
			mnr_q <= '1;
			mxc_q <= '0;
			mxr_q <= '0;
		end else if (en && vld_q[LAT-1]) begin
			if (sd31.eof) begin
				mnc_q <= '1;
				mnr_q <= '1;
				mxc_q <= '0;
				mxr_q <= '0;
			end else begin
				mnc_q <= mnc_n;
				mnr_q <= mnr_n;
				mxc_q <= mxc_n;
				mxr_q <= mxr_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dc_s32 <= dc_s31;
			dr_s32 <= dr_s31;
			cl_s32 <= '0;
			ct_s32 <= '0;
			cw_s32 <= '0;
			ch_s32 <= '0;
			if (sd31.eof) begin
				if (ce_q) begin
					cl_s32 <= mnc_n[11:0];
					ct_s32 <= mnr_n[11:0];
					cw_s32 <= mxc_n - mnc_n;
					ch_s32 <= mxr_n - mnr_n;
				end else begin
					cw_s32 <= w_q;
					ch_s32 <= h_q;
				end
			end
		end
	end

	assign m_tvalid = vld_q[LAT];
	assign m_tlast  = side_q[LAT].eof;
	assign m_tdata  = {4'd0, ch_s32, cw_s32, ct_s32, cl_s32, side_q[LAT].policy,
		side_q[LAT].pixel, dr_s32, dc_s32};

endmodule
`default_nettype wire

[test/fisheye_forward_warp_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisheye_forward_warp_unit_test
// Self-checking bench for the fisheye forward warp. Source pixels are streamed
// in bursts under several register settings, each output item is compared
// field by field with a bit-exact prediction, and the receiver stalls on a
// pattern of its own.
// ----------------------------------------------------------------------------
module fisheye_forward_warp_unit_test;
	import fwu_pkg::*;

	localparam int LIMIT = 500000;
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;

	typedef struct {
		logic [11:0] dest_col;
		logic [11:0] dest_row;
		logic [23:0] pixel;
		policy_t     policy;
		logic        done;
		logic [11:0] left;
		logic [11:0] top;
		logic [12:0] crop_w;
		logic [12:0] crop_h;
	} warp_item_t;

	class warp_scoreboard;
		bit [12:0]  fw, fh;
		bit [15:0]  rscale, cx, cy;
		bit         crop_on;
		bit [12:0]  box_min_col, box_min_row, box_max_col, box_max_row;
		warp_item_t pending_q[$];
		int         errors, results, frames;

		function new();
			fw = 640; fh = 480; rscale = 22938; cx = 0; cy = 0; crop_on = 1;
			reload_box();
		endfunction

		function void reload_box();
			box_min_col = 13'h1FFF; box_min_row = 13'h1FFF;
			box_max_col = 0; box_max_row = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				REG_FRAME_WIDTH:  fw = val[12:0];
				REG_FRAME_HEIGHT: fh = val[12:0];
				REG_RADIUS_SCALE: rscale = val;
				REG_CENTRE_X:     cx = val;
				REG_CENTRE_Y:     cy = val;
				REG_CROP_ENABLE:  crop_on = val[0];
				default: ;
			endcase
		endfunction

		function bit [63:0] used_dim(bit [12:0] r);
			if (r == 0) return 1;
			return (r > MAX_DIM) ? MAX_DIM : r;
		endfunction

		function bit [63:0] mag(longint a);
			return (a < 0) ? bit'(0) - a : a;
		endfunction

		function longint scale_tz(longint a, bit [63:0] b);
			longint p;
			p = longint'((mag(a) * b) >> 16);
			return (a < 0) ? -p : p;
		endfunction

		function bit [63:0] root_floor(bit [63:0] v);
			bit [63:0] res, t;
			res = 0;
			for (int b = 31; b >= 0; b--) begin
				t = res | (64'd1 << b);
				if (t * t <= v) res = t;
			end
			return res;
		endfunction

		function longint to_unit(bit [63:0] c, bit [63:0] dim);
			bit [63:0] q;
			q = (c * 131072) / dim;
			if (q > 131072) q = 131072;
			return longint'(q) - 65536;
		endfunction

		function bit [63:0] to_pixel(longint d, bit [63:0] dim);
			bit [63:0] v;
			if (d < -65536) d = -65536;
			if (d > 65536) d = 65536;
			v = (64'(d + 65536) * dim) / 131072;
			return (v > dim - 1) ? dim - 1 : v;
		endfunction

		function bit [63:0] squeeze_root(bit [63:0] s);
			bit [63:0] i;
			if (s > 65536) s = 65536;
			i = (s * (SQRT_DEPTH - 1)) >> 16;
			return root_floor((i << 32) / (SQRT_DEPTH - 1));
		endfunction

		function bit [63:0] falloff(bit [63:0] u);
			bit [63:0] i, g, term, e;
			longint    acc;
			if (u > (64'd8 << 16)) u = 64'd8 << 16;
			i = (u * (EXP_DEPTH - 1)) >> 19;
			if (i > EXP_DEPTH - 1) i = EXP_DEPTH - 1;
			g = (i << 32) / (EXP_DEPTH - 1);
			term = 64'd1 << 30;
			acc = longint'(64'd1 << 30);
			for (int n = 1; n <= 12; n++) begin
				term = ((term * g) >> 32) / n;
				if (n % 2) acc -= longint'(term);
				else acc += longint'(term);
			end
			e = (acc < 0) ? 64'd0 : 64'(acc);
			repeat (3) e = (e * e) >> 30;
			return e >> 14;
		endfunction

		function void note_input(logic [11:0] col, logic [11:0] row, logic [23:0] pix,
				logic eof);
			bit [63:0]  w, h, sx, sy, ex, ey, d2, k, ef, dc, dr;
			longint     nx, ny, dx, dy;
			warp_item_t x;
			w = used_dim(fw); h = used_dim(fh);
			nx = to_unit(64'(col), w); ny = to_unit(64'(row), h);
			sy = 65536 - ((mag(ny) * mag(ny)) >> 17);
			sx = 65536 - ((mag(nx) * mag(nx)) >> 17);
			dx = scale_tz(nx, squeeze_root(sy));
			dy = scale_tz(ny, squeeze_root(sx));
			ex = mag(dx - longint'($signed(cx)) * 4);
			ey = mag(dy - longint'($signed(cy)) * 4);
			d2 = (ex * ex + ey * ey) >> 16;
			k = (64'(rscale) * rscale) >> 12;
			ef = falloff((k * d2) >> 18);
			dc = to_pixel(scale_tz(dx, ef), w);
			dr = to_pixel(scale_tz(dy, ef), h);
			if (dc < box_min_col) box_min_col = dc[12:0];
			if (dr < box_min_row) box_min_row = dr[12:0];
			if (dc > box_max_col) box_max_col = dc[12:0];
			if (dr > box_max_row) box_max_row = dr[12:0];
			x.dest_col = dc[11:0]; x.dest_row = dr[11:0]; x.pixel = pix;
			x.policy = (col < w / 2) ? POL_OVERWRITE :
				((col > w / 2) ? POL_IF_BLACK : POL_NONE);
			x.done = eof;
			x.left = 0; x.top = 0; x.crop_w = 0; x.crop_h = 0;
			if (eof) begin
				if (crop_on) begin
					x.left = box_min_col[11:0];
					x.top = box_min_row[11:0];
					x.crop_w = box_max_col - box_min_col;
					x.crop_h = box_max_row - box_min_row;
				end else begin
					x.crop_w = w[12:0]; x.crop_h = h[12:0];
				end
				reload_box();
			end
			pending_q = {pending_q, x};
		endfunction

		task report(string what, logic [23:0] got, logic [23:0] want);
			$display("MISMATCH result %0d: %s got %0h want %0h", results, what, got, want);
			errors++;
		endtask

		task check_result(logic [103:0] d, logic last);
			warp_item_t x;
			results++;
			if (last) frames++;
			if (pending_q.size() == 0) begin
				report("unexpected item", d[23:0], 24'd0);
				return;
			end
			x = pending_q.pop_front();
			if (d[11:0] != x.dest_col)
				report("dest_col", 24'(d[11:0]), 24'(x.dest_col));
			if (d[23:12] != x.dest_row)
				report("dest_row", 24'(d[23:12]), 24'(x.dest_row));
			if (d[47:24] != x.pixel) report("dest_pixel", d[47:24], x.pixel);
			if (d[49:48] != x.policy)
				report("write_policy", 24'(d[49:48]), 24'(x.policy));
			if (last != x.done) report("frame_done", 24'(last), 24'(x.done));
			if (d[61:50] != x.left) report("crop_left", 24'(d[61:50]), 24'(x.left));
			if (d[73:62] != x.top) report("crop_top", 24'(d[73:62]), 24'(x.top));
			if (d[86:74] != x.crop_w)
				report("crop_width", 24'(d[86:74]), 24'(x.crop_w));
			if (d[99:87] != x.crop_h)
				report("crop_height", 24'(d[99:87]), 24'(x.crop_h));
		endtask
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         cfg_we = 0;
	logic [2:0]   cfg_index = 0;
	logic [15:0]  cfg_data = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [47:0]  s_tdata = 0;
	logic         s_tlast = 0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [103:0] m_tdata;
	logic         m_tlast;

	warp_scoreboard sb;
	int cycles = 0;
	int burst_left = 0;
	int sent = 0;

	fisheye_forward_warp_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: steady, light, heavy and long-stall stretches in turn
	always @(posedge clk) begin
		case (cycles[9:8])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= ($urandom_range(0, 3) != 0);
			2'd2: m_tready <= ($urandom_range(0, 1) != 0);
			default: m_tready <= (cycles[4:0] > 5'd20);
		endcase
	end

	always @(posedge clk)
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast);

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic setup(logic [15:0] w, logic [15:0] h, logic [15:0] rs, logic [15:0] x,
			logic [15:0] y, logic crop);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_RADIUS_SCALE, rs);
		write_reg(REG_CENTRE_X, x);
		write_reg(REG_CENTRE_Y, y);
		write_reg(REG_CROP_ENABLE, {15'd0, crop});
		repeat (2) @(posedge clk);
	endtask

	task automatic push_pixel(logic [11:0] col, logic [11:0] row, logic [23:0] pix,
			logic eof);
		s_tvalid <= 1'b1;
		s_tdata <= {pix, row, col};
		s_tlast <= eof;
		do @(posedge clk); while (!s_tready);
		sb.note_input(col, row, pix, eof);
		sent++;
	endtask

	// sender: bursts of random length, random gaps between them
	task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [23:0] pix,
			logic eof);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push_pixel(col, row, pix, eof);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	task automatic random_pixels(int count);
		int w, h;
		logic [11:0] col, row;
		w = int'(sb.used_dim(sb.fw));
		h = int'(sb.used_dim(sb.fh));
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 9))
				0, 1: begin col = 12'($urandom); row = 12'($urandom); end
				2: begin col = 12'(w / 2); row = 12'($urandom_range(0, h - 1)); end
				default: begin
					col = 12'($urandom_range(0, w - 1));
					row = 12'($urandom_range(0, h - 1));
				end
			endcase
			send_pixel(col, row, 24'($urandom), $urandom_range(0, 24) == 0);
			if (n == count / 2 && count > 100) drain();
		end
		send_pixel(12'($urandom_range(0, w - 1)), 12'($urandom_range(0, h - 1)),
			24'($urandom), 1'b1);
		drain();
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// defaults from reset: corners, centre column, out-of-frame, colour extremes
		send_pixel(12'd0, 12'd0, 24'h000000, 1'b0);
		send_pixel(12'd639, 12'd479, 24'hFFFFFF, 1'b0);
		send_pixel(12'd319, 12'd240, 24'hA5A5A5, 1'b0);
		send_pixel(12'd320, 12'd240, 24'h5A5A5A, 1'b0);
		send_pixel(12'd321, 12'd240, 24'h123456, 1'b0);
		send_pixel(12'd640, 12'd480, 24'hFFFFFF, 1'b0);
		send_pixel(12'hFFF, 12'hFFF, 24'h000000, 1'b0);
		send_pixel(12'd0, 12'hFFF, 24'hFFFFFF, 1'b0);
		send_pixel(12'd320, 12'd0, 24'h800001, 1'b1);
		send_pixel(12'd100, 12'd100, 24'h7FFFFE, 1'b1);
		drain();

		// tiny frame, zero radius, centre at the corners of its range
		setup(16'd1, 16'd1, 16'd0, 16'h8000, 16'h7FFF, 1'b1);
		write_reg(REG_SPARE_6, 16'($urandom));
		write_reg(REG_SPARE_7, 16'($urandom));
		send_pixel(12'd0, 12'd0, 24'h010203, 1'b1);
		send_pixel(12'd1, 12'd5, 24'h040506, 1'b1);
		random_pixels(140);

		// largest frame, strongest radius, crop off
		setup(16'd4096, 16'd4096, 16'hFFFF, 16'h7FFF, 16'h8000, 1'b0);
		send_pixel(12'd2048, 12'd2048, 24'hFFFFFF, 1'b1);
		random_pixels(140);

		// zero width and oversize height
		setup(16'd0, 16'd8191, 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
		random_pixels(140);

		// small odd frame near the defaults
		setup(16'd17, 16'd12, 16'd22938, 16'd0, 16'd0, 1'b1);
		random_pixels(160);

		for (int p = 0; p < 3; p++) begin
			setup(16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)),
				16'($urandom), 16'($urandom), 16'($urandom), $urandom_range(0, 1) != 0);
			random_pixels(140);
		end

		setup(16'd640, 16'd480, 16'd22938, 16'd0, 16'd0, 1'b1);
		random_pixels(60);

		$display("Covered %0d source pixels and %0d results over nine register settings,",
			sent, sb.results);
		$display("including %0d frame ends with and without cropping.", sb.frames);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

[filelist.f]
sv/fwu_pkg.sv
sv/fisheye_forward_warp_unit.sv
test/fisheye_forward_warp_unit_test.sv
